[design/asd_pkg.sv]
package asd_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned MagW     = 17;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned IntW     = 16;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [MagW-1:0] BaseMargin = MagW'(100);
  localparam int unsigned     FiltShift  = 3;
  localparam int unsigned     BaseShift  = 6;

  localparam logic [MagW-1:0] HighThrRst = MagW'(450);
  localparam logic [MagW-1:0] LowThrRst  = MagW'(150);
  localparam logic [IntW-1:0] MinIntRst  = IntW'(300);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_MIN_INT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MagW-1:0] high_thr;
    logic [MagW-1:0] low_thr;
    logic [IntW-1:0] min_int;
  } cfg_t;

  // item after the lane merge
  typedef struct packed {
    logic             action;
    logic [MagW-1:0]  mag;
    logic [TimeW-1:0] time_ms;
  } mag_item_t;

  typedef struct packed {
    logic [CountW-1:0] step_total;
    logic              step_counted;
    logic              armed;
    logic [MagW-1:0]   smoothed;
  } result_t;

endpackage

[design/asd_lane.sv]
module asd_lane
  import asd_pkg::*;
(
  input  logic signed [AxisW-1:0] axis_i,
  output logic [AxisW-1:0]        abs_o
);

  // -32768 maps to 32768, which still fits unsigned
  assign abs_o = axis_i[AxisW-1] ? AxisW'(-axis_i) : AxisW'(axis_i);

endmodule

[design/asd_merge.sv]
module asd_merge
  import asd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   action_i,
  input  logic [AxisW-1:0]       lane_abs_i [NumAxes],
  input  logic [TimeW-1:0]       time_ms_i,
  output logic                   item_valid_o,
  output mag_item_t              item_o,
  input  logic                   item_take_i
);

  logic      valid_q, valid_d;
  mag_item_t item_q, item_d;
  logic [MagW-1:0] mag_sum;

  always_comb begin
    mag_sum = '0;
    for (int i = 0; i < NumAxes; i++) begin
      mag_sum = mag_sum + MagW'(lane_abs_i[i]);
    end
  end

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
    if (in_valid_i && in_ready_o) begin
      item_d.action  = action_i;
      item_d.mag     = mag_sum;
      item_d.time_ms = time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[design/asd_tracker.sv]
module asd_tracker
  import asd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  input  mag_item_t item_i,
  output logic      item_take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   res_o
);

  logic [MagW-1:0]   filt_q, filt_d;
  logic [MagW-1:0]   base_q, base_d;
  logic              armed_q, armed_d;
  logic [CountW-1:0] steps_q, steps_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic signed [MagW:0] diff;
  logic signed [MagW:0] diff_sh;
  logic [MagW-1:0]      filt_new;
  logic [MagW-1:0]      excess;
  logic [MagW-1:0]      base_new;
  logic [MagW-1:0]      delta;
  logic                 arm;
  logic                 disarm;
  logic [TimeW-1:0]     elapsed;
  logic                 counted;
  logic                 upd;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign upd         = item_take_o;

  always_comb begin
    diff     = $signed({1'b0, item_i.mag}) - $signed({1'b0, filt_q});
    diff_sh  = diff >>> FiltShift;
    filt_new = (filt_q == '0) ? item_i.mag : filt_q + diff_sh[MagW-1:0];

    excess   = filt_new - base_q;
    if (filt_new < base_q) begin
      base_new = filt_new;
    end else if (excess > BaseMargin) begin
      base_new = base_q + ((excess - BaseMargin) >> BaseShift);
    end else begin
      base_new = base_q;
    end

    delta   = filt_new - base_new;
    arm     = armed_q || (delta > cfg_i.high_thr);
    disarm  = arm && (delta < cfg_i.low_thr);
    elapsed = item_i.time_ms - last_q;
    counted = disarm && (elapsed >= TimeW'(cfg_i.min_int));
  end

  always_comb begin
    filt_d      = filt_q;
    base_d      = base_q;
    armed_d     = armed_q;
    steps_d     = steps_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (upd) begin
      out_valid_d = 1'b1;
      if (item_i.action) begin
        steps_d = '0;
      end else begin
        filt_d  = filt_new;
        base_d  = base_new;
        armed_d = arm && !disarm;
        if (counted) begin
          steps_d = steps_q + 1'b1;
          last_d  = item_i.time_ms;
        end
      end
      res_d.step_total   = steps_d;
      res_d.step_counted = !item_i.action && counted;
      res_d.armed        = armed_d;
      res_d.smoothed     = filt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      base_q      <= '0;
      armed_q     <= 1'b0;
      steps_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      filt_q      <= filt_d;
      base_q      <= base_d;
      armed_q     <= armed_d;
      steps_q     <= steps_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_base_le_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= filt_q)
    else $error("baseline above filtered magnitude");

  a_count_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.step_counted |-> !res_q.armed)
    else $error("step counted while still armed");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && !item_i.action && counted |=> steps_q == $past(steps_q) + 1'b1)
    else $error("step count did not advance");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && item_i.action |=> steps_q == '0 && $stable(filt_q) && $stable(armed_q))
    else $error("clear transaction disturbed detector state");

endmodule

[design/accel_step_detector.sv]
// Step counter fed with accelerometer samples.
// Input channel: in_valid_i/in_ready_o with action_i, accel_x/y/z_i and
// time_ms_i. action_i = 0 processes a sample, 1 clears the step count only.
// Output channel: out_valid_o/out_ready_i with step_total_o, step_counted_o,
// armed_o and smoothed_magnitude_o; one result per input transaction.
// Config channel: cfg_valid_i/cfg_ready_o, cfg_index_i selects high
// threshold (0), low threshold (1) or minimum step interval (2); other
// indexes are ignored. Write only while no transaction is in flight.
// A result passes the merge register, then the tracker register; a stalled
// receiver holds it back. Throughput: one transaction per cycle while the
// receiver does not stall; three axis lanes and an adder stage feed a
// combinational filter/baseline/detector update in the tracker.
// Reset clears the filter, baseline, armed flag, count and last step time
// and restores the register defaults (450, 150, 300 ms).
// When the receiver stalls, the result is held and the merge stage still
// takes one more transaction before in_ready_o drops.
module accel_step_detector
  import asd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    action_i,
  input  logic signed [AxisW-1:0] accel_x_i,
  input  logic signed [AxisW-1:0] accel_y_i,
  input  logic signed [AxisW-1:0] accel_z_i,
  input  logic [TimeW-1:0]        time_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CountW-1:0]       step_total_o,
  output logic                    step_counted_o,
  output logic                    armed_o,
  output logic [MagW-1:0]         smoothed_magnitude_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  cfg_t                    cfg_q, cfg_d;
  logic signed [AxisW-1:0] axis [NumAxes];
  logic [AxisW-1:0]        lane_abs [NumAxes];
  logic                    item_valid;
  mag_item_t               item;
  logic                    item_take;
  result_t                 res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HIGH_THR: cfg_d.high_thr = cfg_data_i[MagW-1:0];
        CFG_LOW_THR:  cfg_d.low_thr  = cfg_data_i[MagW-1:0];
        CFG_MIN_INT:  cfg_d.min_int  = cfg_data_i[IntW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr <= HighThrRst;
      cfg_q.low_thr  <= LowThrRst;
      cfg_q.min_int  <= MinIntRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign axis[0] = accel_x_i;
  assign axis[1] = accel_y_i;
  assign axis[2] = accel_z_i;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    asd_lane u_lane (
      .axis_i (axis[g]),
      .abs_o  (lane_abs[g])
    );
  end

  asd_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .lane_abs_i   (lane_abs),
    .time_ms_i    (time_ms_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  asd_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign step_total_o         = res.step_total;
  assign step_counted_o       = res.step_counted;
  assign armed_o              = res.armed;
  assign smoothed_magnitude_o = res.smoothed;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import asd_pkg::*;

  localparam int unsigned          QuietLimit  = 1000;
  localparam logic [CfgIdxW-1:0]   CfgIdxSpare = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    action_i;
  logic signed [AxisW-1:0] accel_x_i;
  logic signed [AxisW-1:0] accel_y_i;
  logic signed [AxisW-1:0] accel_z_i;
  logic [TimeW-1:0]        time_ms_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [CountW-1:0]       step_total_o;
  logic                    step_counted_o;
  logic                    armed_o;
  logic [MagW-1:0]         smoothed_magnitude_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]     cfg_data_i;

  accel_step_detector DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .accel_x_i            (accel_x_i),
    .accel_y_i            (accel_y_i),
    .accel_z_i            (accel_z_i),
    .time_ms_i            (time_ms_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .step_total_o         (step_total_o),
    .step_counted_o       (step_counted_o),
    .armed_o              (armed_o),
    .smoothed_magnitude_o (smoothed_magnitude_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pedometer state as the block should hold it
  cfg_t              cfg_regs;
  int                filt_mag;
  int                baseline;
  bit                armed_now;
  logic [CountW-1:0] step_count;
  logic [TimeW-1:0]  last_step_ms;

  result_t           step_reports[$];
  int                fail_count;
  int                n_items;
  int                n_clears;
  int                n_steps;
  int                n_writes;
  int                stall_left;
  int unsigned       quiet_cycles;
  bit                steady;
  logic [TimeW-1:0]  clock_ms;

  function automatic void reset_pedometer();
    cfg_regs.high_thr = HighThrRst;
    cfg_regs.low_thr  = LowThrRst;
    cfg_regs.min_int  = MinIntRst;
    filt_mag     = 0;
    baseline     = 0;
    armed_now    = 1'b0;
    step_count   = '0;
    last_step_ms = '0;
  endfunction

  function automatic int axis_mag(logic signed [AxisW-1:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic result_t track_step(logic act, logic signed [AxisW-1:0] x,
                                         logic signed [AxisW-1:0] y,
                                         logic signed [AxisW-1:0] z,
                                         logic [TimeW-1:0] now);
    int               mag;
    int               delta;
    logic [TimeW-1:0] elapsed;
    result_t          r;
    r.step_counted = 1'b0;
    if (act) begin
      step_count = '0;
      n_clears++;
    end else begin
      mag = axis_mag(x) + axis_mag(y) + axis_mag(z);
      if (filt_mag == 0) begin
        filt_mag = mag;
      end else begin
        filt_mag = filt_mag + ((mag - filt_mag) >>> FiltShift);
      end
      if (filt_mag < baseline) begin
        baseline = filt_mag;
      end else if (filt_mag - baseline > int'(BaseMargin)) begin
        baseline = baseline + ((filt_mag - baseline - int'(BaseMargin)) >>> BaseShift);
      end
      delta = filt_mag - baseline;
      if (delta > int'(cfg_regs.high_thr) && !armed_now) armed_now = 1'b1;
      if (delta < int'(cfg_regs.low_thr) && armed_now) begin
        armed_now = 1'b0;
        elapsed = now - last_step_ms;
        if (elapsed >= TimeW'(cfg_regs.min_int)) begin
          step_count     = step_count + 1'b1;
          last_step_ms   = now;
          r.step_counted = 1'b1;
          n_steps++;
        end
      end
    end
    r.step_total = step_count;
    r.armed      = armed_now;
    r.smoothed   = MagW'(filt_mag);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // receiver stalls
  always @(negedge clk_i) begin
    if (stall_left != 0 && !steady) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
      stall_left  = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (step_reports.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, total %0h", $time, step_total_o);
      end else begin
        want = step_reports.pop_front();
        check_field("step_total", want.step_total, step_total_o);
        check_field("step_counted", want.step_counted, step_counted_o);
        check_field("armed", want.armed, armed_o);
        check_field("smoothed_magnitude", want.smoothed, smoothed_magnitude_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic act, logic signed [AxisW-1:0] x,
                           logic signed [AxisW-1:0] y, logic signed [AxisW-1:0] z,
                           logic [TimeW-1:0] now);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    accel_x_i  = x;
    accel_y_i  = y;
    accel_z_i  = z;
    time_ms_i  = now;
    do @(posedge clk_i); while (!in_ready_o);
    step_reports.push_back(track_step(act, x, y, z, now));
    n_items++;
  endtask

  // drain everything in flight before touching registers
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (step_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HIGH_THR: cfg_regs.high_thr = data;
      CFG_LOW_THR:  cfg_regs.low_thr  = data;
      CFG_MIN_INT:  cfg_regs.min_int  = data[IntW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_config(int hi, int lo, int mi);
    settle();
    write_reg(CFG_HIGH_THR, CfgDataW'(hi));
    write_reg(CFG_LOW_THR, CfgDataW'(lo));
    write_reg(CFG_MIN_INT, CfgDataW'(mi));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [AxisW-1:0] axis_near(int amp);
    int v;
    v = $urandom_range(amp * 5 / 4, amp * 3 / 4);
    return $urandom_range(0, 1) ? AxisW'(-v) : AxisW'(v);
  endfunction

  function automatic logic signed [AxisW-1:0] rand_axis();
    return AxisW'($urandom());
  endfunction

  // defaults from reset; reload from zero, full-scale axes, negative filter step
  task automatic test_extremes();
    send_item(1'b0, 0, 0, 0, 32'd0);
    send_item(1'b0, -32768, -32768, -32768, 32'd1000);
    send_item(1'b0, 32767, 32767, 32767, 32'd1010);
    send_item(1'b0, -1, 0, 1, 32'd1020);
    send_item(1'b1, 16'h5555, 16'haaaa, 16'h0f0f, 32'hffff_ffff);
    send_item(1'b0, 16'h7fff, -32768, 0, 32'h8000_0000);
  endtask

  // low above high: arm and disarm in one transaction, interval limits, time wrap
  task automatic test_arm_disarm();
    set_config(0, 98304, 300);
    send_item(1'b0, 2000, -3000, 1500, 32'd5000);
    send_item(1'b0, -2500, 3000, 1000, 32'd5100);
    send_item(1'b0, 1800, 2600, -1400, 32'd5400);
    send_item(1'b1, -7, 9, 3, 32'd5450);
    send_item(1'b0, 2100, -2900, 1300, 32'hffff_fff0);
    send_item(1'b0, -2200, 2700, 1600, 32'h0000_0010);
    send_item(1'b0, 2300, 2400, -1700, 32'h0000_0200);
    set_config(0, 98304, 65535);
    send_item(1'b0, 2500, -2500, 1500, 32'h0000_0200 + 32'd65534);
    send_item(1'b0, -2400, 2600, 1400, 32'h0000_0200 + 32'd65535);
    set_config(0, 98304, 0);
    send_item(1'b0, 2600, 2200, -1900, 32'h0002_0000);
    send_item(1'b0, -2700, 2100, 1800, 32'h0002_0000);
  endtask

  task automatic test_threshold_extremes();
    set_config(98304, 0, 300);
    send_item(1'b0, -32768, -32768, -32768, 32'h0003_0000);
    send_item(1'b0, 0, 0, 0, 32'h0003_1000);
    set_config(450, 150, 300);
  endtask

  // writes to the unmapped index must leave all registers alone
  task automatic test_spare_index();
    settle();
    write_reg(CfgIdxSpare, CfgDataW'($urandom()));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    send_item(1'b0, 9000, -8000, 7000, 32'h0004_0000);
    send_item(1'b0, 10, -20, 30, 32'h0004_0400);
  endtask

  // stride-like bursts with noise and stray clears mixed in
  task automatic walk_phase(int n_target);
    int sent;
    int run;
    int amp;
    int r;
    bit high;
    sent = 0;
    high = 1'b0;
    while (sent < n_target) begin
      high = !high;
      run  = high ? $urandom_range(2, 8) : $urandom_range(10, 40);
      amp  = high ? $urandom_range(2000, 12000) : $urandom_range(0, 400);
      for (int k = 0; k < run && sent < n_target; k++) begin
        clock_ms = clock_ms + $urandom_range(5, 80);
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(1'b1, rand_axis(), rand_axis(), rand_axis(), $urandom());
        end else if (r < 9) begin
          send_item(1'b0, rand_axis(), rand_axis(), rand_axis(), clock_ms);
        end else begin
          send_item(1'b0, axis_near(amp), axis_near(amp), axis_near(amp), clock_ms);
        end
        sent++;
      end
    end
  endtask

  task automatic test_random_walk();
    int hi;
    int lo;
    int mi;
    clock_ms = $urandom();
    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        hi = $urandom_range(0, 1) ? 0 : 98304;
        lo = $urandom_range(0, 1) ? 0 : 98304;
        mi = $urandom_range(0, 1) ? 0 : 65535;
      end else if (p % 2 == 1) begin
        hi = $urandom_range(0, 600);
        lo = $urandom_range(hi, 98304);
        mi = $urandom_range(0, 17'h1ffff);
      end else begin
        hi = $urandom_range(200, 3000);
        lo = $urandom_range(0, hi);
        mi = $urandom_range(0, 400);
      end
      if (p == 4) clock_ms = 32'hffff_f000 + $urandom_range(0, 255);
      set_config(hi, lo, mi);
      steady = (p == 2);
      walk_phase(70);
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = 1'b0;
    accel_x_i    = '0;
    accel_y_i    = '0;
    accel_z_i    = '0;
    time_ms_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_HIGH_THR;
    cfg_data_i   = '0;
    out_ready_i  = 1'b0;
    stall_left   = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    fail_count   = 0;
    n_items      = 0;
    n_clears     = 0;
    n_steps      = 0;
    n_writes     = 0;
    reset_pedometer();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_arm_disarm();
    test_threshold_extremes();
    test_spare_index();
    test_random_walk();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (step_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Covered %0d transactions (%0d clears) across %0d register writes,",
             n_items, n_clears, n_writes);
    $display("including threshold extremes, time wrap and %0d counted steps.", n_steps);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
